FILE: design/cpts_pkg.sv
// Shared types and constants for the task scheduler.
package cpts_pkg;

    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_SLEEPING = 2'd1;
    localparam logic [1:0] ST_EXITED   = 2'd2;

    localparam logic [2:0] FN_TICK    = 3'd0;
    localparam logic [2:0] FN_SLEEP   = 3'd1;
    localparam logic [2:0] FN_YIELD   = 3'd2;
    localparam logic [2:0] FN_INSTALL = 3'd3;
    localparam logic [2:0] FN_EXIT    = 3'd4;

    localparam logic [9:0] MS_PER_SECOND = 10'd1000;
    localparam logic [8:0] COUNTER_MAX   = 9'd511;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] counter;
        logic [7:0] prio;
        logic [31:0] wake;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE, S_OP_RD, S_OP_WR, S_WAKE_RD, S_WAKE_WR,
        S_PICK_RD, S_PICK_CHK, S_RECH_RD, S_RECH_WR, S_OUT
    } t_state;

endpackage

FILE: design/counter_priority_task_scheduler.sv
// Top level: slot table in a one-port synchronous memory, sequenced read-modify-write passes.
// Install and unknown functions go straight to the result; exit and non-scheduling ticks
// take a read and a write state first. A scheduling pass adds a wake sweep and a pick over
// all slots, and, while the best running counter is zero, up to two recharge sweeps, each
// followed by a re-pick. A new request is taken only when idle and the last result is taken.
// Reset (synchronous, active low) clears present bits, current task and control only.
module counter_priority_task_scheduler
    import cpts_pkg::*;
#(
    parameter int TASK_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_sleep_seconds,
    input  logic [3:0]  i_task_slot,
    input  logic [7:0]  i_task_priority,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_next_task,
    output logic        o_switched,
    output logic        o_idle_fallback
);
    localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    t_slot mem [TASK_SLOTS];
    t_slot r_rd;
    logic [TASK_SLOTS-1:0] r_present, n_present;

    t_state r_state, n_state;
    logic [2:0]  r_func;
    logic [31:0] r_now, r_wake_new;
    logic [3:0]  r_slot;
    logic [AW-1:0] r_cur, n_cur, r_idx, n_idx, r_best, n_best;
    logic [9:0]  r_top, n_top;   // bit 9: none found
    logic [1:0]  r_pass, n_pass;
    logic        r_run, n_run, r_idle, n_idle;
    logic        r_ovalid, n_ovalid;

    logic          mem_we, rd_en;
    logic [AW-1:0] mem_addr;
    t_slot         mem_wd;
    logic          slot_ok;
    logic [AW-1:0] in_slot;
    logic [8:0]    tick_cnt;
    logic [9:0]    rech_sum;
    logic          last_idx;

    assign slot_ok  = ({28'd0, i_task_slot} < 32'(TASK_SLOTS));
    assign in_slot  = AW'(i_task_slot);
    assign last_idx = (r_idx == AW'(TASK_SLOTS - 1));
    assign tick_cnt = (r_rd.counter != 9'd0) ? r_rd.counter - 9'd1 : 9'd0;
    assign rech_sum = {2'd0, r_rd.prio} + {2'd0, r_rd.counter[8:1]};

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wd;
        if (rd_en)  r_rd <= mem[mem_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && !r_ovalid) begin
                    case (i_func)
                        FN_TICK, FN_SLEEP, FN_EXIT: n_state = S_OP_RD;
                        FN_YIELD:                   n_state = S_WAKE_RD;
                        default:                    n_state = S_OUT;
                    endcase
                end
            end
            S_OP_RD: n_state = S_OP_WR;
            S_OP_WR: n_state = n_run ? S_WAKE_RD : S_OUT;
            S_WAKE_RD: n_state = S_WAKE_WR;
            S_WAKE_WR: n_state = last_idx ? S_PICK_RD : S_WAKE_RD;
            S_PICK_RD: n_state = S_PICK_CHK;
            S_PICK_CHK: begin
                if (!last_idx) n_state = S_PICK_RD;
                else if (n_top == 10'd0 && r_pass != 2'd2) n_state = S_RECH_RD;
                else n_state = S_OUT;
            end
            S_RECH_RD: n_state = S_RECH_WR;
            S_RECH_WR: n_state = last_idx ? S_PICK_RD : S_RECH_RD;
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_present = r_present;
        n_cur = r_cur;
        n_idx = r_idx;
        n_best = r_best;
        n_top = r_top;
        n_pass = r_pass;
        n_run = r_run;
        n_idle = r_idle;
        n_ovalid = r_ovalid && !i_ready;
        mem_we = 1'b0;
        rd_en = 1'b0;
        mem_addr = r_idx;
        mem_wd = r_rd;
        o_ready = (r_state == S_IDLE) && !r_ovalid;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                n_pass = 2'd0;
                if (i_valid && !r_ovalid) begin
                    n_run = 1'b0;
                    n_idle = 1'b0;
                    if (i_func == FN_YIELD) n_run = 1'b1;
                    if (i_func == FN_INSTALL && slot_ok) begin
                        mem_we = 1'b1;
                        mem_addr = in_slot;
                        mem_wd.status = ST_RUNNING;
                        mem_wd.prio = (i_task_priority == 8'd0) ? 8'd1 : i_task_priority;
                        mem_wd.counter = {1'b0, mem_wd.prio};
                        mem_wd.wake = '0;
                        n_present[in_slot] = 1'b1;
                    end
                    if (i_func == FN_TICK || i_func == FN_SLEEP) begin
                        rd_en = 1'b1;
                        mem_addr = r_cur;
                    end else if (i_func == FN_EXIT) begin
                        rd_en = 1'b1;
                        mem_addr = in_slot;
                    end
                end
            end
            S_OP_RD: begin
                // read data now in r_rd
            end
            S_OP_WR: begin
                case (r_func)
                    FN_TICK: begin
                        if (r_present[r_cur]) begin
                            mem_we = 1'b1;
                            mem_addr = r_cur;
                            mem_wd.counter = tick_cnt;
                            n_run = (tick_cnt == 9'd0);
                        end else begin
                            n_run = 1'b1;
                        end
                    end
                    FN_SLEEP: begin
                        mem_we = 1'b1;
                        mem_addr = r_cur;
                        mem_wd.wake = r_wake_new;
                        mem_wd.status = ST_SLEEPING;
                        // absent slot: fields other than wake are undefined anyway
                        n_run = 1'b1;
                    end
                    FN_EXIT: begin
                        if ({28'd0, r_slot} < 32'(TASK_SLOTS) && r_present[AW'(r_slot)]) begin
                            mem_we = 1'b1;
                            mem_addr = AW'(r_slot);
                            mem_wd.status = ST_EXITED;
                        end
                    end
                    default: ;
                endcase
            end
            S_WAKE_RD: begin
                rd_en = 1'b1;
            end
            S_WAKE_WR: begin
                if (r_present[r_idx] && r_rd.status != ST_EXITED && r_now > r_rd.wake) begin
                    mem_we = 1'b1;
                    mem_wd.status = ST_RUNNING;
                end
                n_idx = last_idx ? '0 : r_idx + AW'(1);
                n_top = 10'h200;
                n_best = '0;
            end
            S_PICK_RD: begin
                rd_en = 1'b1;
            end
            S_PICK_CHK: begin
                if (r_present[r_idx] && r_rd.status == ST_RUNNING &&
                    (r_top[9] || {1'b0, r_rd.counter} > r_top)) begin
                    n_top = {1'b0, r_rd.counter};
                    n_best = r_idx;
                end
                n_idx = last_idx ? '0 : r_idx + AW'(1);
                if (last_idx) begin
                    if (n_top == 10'd0 && r_pass != 2'd2) begin
                        n_pass = r_pass + 2'd1;
                    end else begin
                        n_cur = n_top[9] ? '0 : n_best;
                        n_idle = n_top[9];
                    end
                end
            end
            S_RECH_RD: begin
                rd_en = 1'b1;
            end
            S_RECH_WR: begin
                if (r_present[r_idx]) begin
                    mem_we = 1'b1;
                    mem_wd.counter = (rech_sum > {1'b0, COUNTER_MAX}) ? COUNTER_MAX : rech_sum[8:0];
                end
                n_idx = last_idx ? '0 : r_idx + AW'(1);
                n_top = 10'h200;
                n_best = '0;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_present <= '0;
            r_cur <= '0;
            r_ovalid <= 1'b0;
            r_idx <= '0;
            r_pass <= 2'd0;
            r_run <= 1'b0;
            r_idle <= 1'b0;
        end else begin
            r_state <= n_state;
            r_present <= n_present;
            r_cur <= n_cur;
            r_ovalid <= n_ovalid;
            r_idx <= n_idx;
            r_pass <= n_pass;
            r_run <= n_run;
            r_idle <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_best <= n_best;
        if (o_ready && i_valid) begin
            r_func <= i_func;
            r_now <= i_now_ms;
            r_slot <= i_task_slot;
            r_wake_new <= i_now_ms + {16'd0, i_sleep_seconds} * {22'd0, MS_PER_SECOND};
        end
    end

    assign o_valid = r_ovalid;
    assign o_next_task = 4'(r_cur);
    assign o_switched = r_run;
    assign o_idle_fallback = r_idle;
endmodule

FILE: verif/tb_top.sv
// Testbench for the task scheduler: table-driven directed beats, then random traffic.
`timescale 1ns / 1ps
module tb_top
    import cpts_pkg::*;
;

    localparam int SLOTS = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_func;
    logic [31:0] i_now_ms;
    logic [15:0] i_sleep_seconds;
    logic [3:0]  i_task_slot;
    logic [7:0]  i_task_priority;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_next_task;
    logic        o_switched;
    logic        o_idle_fallback;

    counter_priority_task_scheduler #(.TASK_SLOTS(SLOTS)) dut (.*);

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] now;
        logic [15:0] secs;
        logic [3:0]  slot;
        logic [7:0]  prio;
    } t_cmd;

    typedef struct packed {
        logic       known;
        logic [3:0] next;
        logic       sw;
        logic       idle;
    } t_row_exp;

    typedef struct packed {
        logic [3:0] next;
        logic       sw;
        logic       idle;
    } t_sched_out;

    // scheduler shadow state
    logic        pres [SLOTS];
    logic [1:0]  stat [SLOTS];
    logic [8:0]  cnt  [SLOTS];
    logic [7:0]  pri  [SLOTS];
    logic [31:0] wake [SLOTS];
    logic [3:0]  cur;

    t_sched_out sched_q[$];
    int errors;

    function automatic t_sched_out predict_sched(t_cmd c);
        t_sched_out r;
        logic run;
        logic [7:0] p;
        int top;
        logic [3:0] best;
        logic [9:0] sum;
        run = 1'b0;
        r.idle = 1'b0;
        case (c.func)
            FN_TICK: begin
                if (pres[cur]) begin
                    if (cnt[cur] != 0) cnt[cur] = cnt[cur] - 1;
                    run = (cnt[cur] == 0);
                end else begin
                    run = 1'b1;
                end
            end
            FN_SLEEP: begin
                wake[cur] = c.now + 32'(MS_PER_SECOND) * 32'(c.secs);
                stat[cur] = ST_SLEEPING;
                run = 1'b1;
            end
            FN_YIELD: run = 1'b1;
            FN_INSTALL: begin
                p = (c.prio == 0) ? 8'd1 : c.prio;
                pres[c.slot] = 1'b1;
                stat[c.slot] = ST_RUNNING;
                pri[c.slot] = p;
                cnt[c.slot] = 9'(p);
                wake[c.slot] = '0;
            end
            FN_EXIT: if (pres[c.slot]) stat[c.slot] = ST_EXITED;
            default: ;
        endcase
        if (run) begin
            for (int i = 0; i < SLOTS; i++)
                if (pres[i] && stat[i] != ST_EXITED && c.now > wake[i]) stat[i] = ST_RUNNING;
            top = -1;
            best = 0;
            for (int pass = 0; pass < 3; pass++) begin
                top = -1;
                best = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (pres[i] && stat[i] == ST_RUNNING && int'(cnt[i]) > top) begin
                        top = int'(cnt[i]);
                        best = 4'(i);
                    end
                if (top != 0) break;
                for (int i = 0; i < SLOTS; i++)
                    if (pres[i]) begin
                        sum = 10'(pri[i]) + 10'(cnt[i] >> 1);
                        cnt[i] = (sum > 10'(COUNTER_MAX)) ? COUNTER_MAX : sum[8:0];
                    end
            end
            r.idle = (top < 0);
            cur = best;
        end
        r.next = cur;
        r.sw = run;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // directed table; expected values only where obvious
    t_cmd     dir_cmd[$];
    t_row_exp dir_exp[$];

    task automatic add_row(logic [2:0] f, logic [31:0] n, logic [15:0] s, logic [3:0] sl,
                           logic [7:0] p, t_row_exp e);
        dir_cmd.push_back({f, n, s, sl, p});
        dir_exp.push_back(e);
    endtask

    t_row_exp row_exp_q[$];

    task automatic send_beat(t_cmd c, t_row_exp e);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= c.func;
        i_now_ms <= c.now;
        i_sleep_seconds <= c.secs;
        i_task_slot <= c.slot;
        i_task_priority <= c.prio;
        sched_q.push_back(predict_sched(c));
        row_exp_q.push_back(e);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // drain checker
    initial begin
        int hold;
        t_sched_out ex;
        t_row_exp re;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            hold = $urandom_range(0, 11);
            if ($urandom_range(0, 3) == 0) hold = 0;
            if (hold > 0) begin
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (sched_q.size() == 0) begin
                $display("%0t: unexpected beat next=%0d", $time, o_next_task);
                errors++;
            end else begin
                ex = sched_q.pop_front();
                re = row_exp_q.pop_front();
                if (re.known && {re.next, re.sw, re.idle} != ex) begin
                    $display("%0t: table row disagrees with predictor exp=%h got=%h", $time,
                             {re.next, re.sw, re.idle}, ex);
                    errors++;
                end
                if (o_next_task !== ex.next) begin
                    $display("%0t: next_task exp=%0d got=%0d", $time, ex.next, o_next_task);
                    errors++;
                end
                if (o_switched !== ex.sw) begin
                    $display("%0t: switched exp=%0d got=%0d", $time, ex.sw, o_switched);
                    errors++;
                end
                if (o_idle_fallback !== ex.idle) begin
                    $display("%0t: idle_fallback exp=%0d got=%0d", $time, ex.idle,
                             o_idle_fallback);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_cmd c;
        t_row_exp nk;
        int r;
        logic [31:0] clock_ms;
        errors = 0;
        nk = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = FN_YIELD;
        i_now_ms = '0;
        i_sleep_seconds = '0;
        i_task_slot = '0;
        i_task_priority = '0;
        for (int i = 0; i < SLOTS; i++) begin
            pres[i] = 0; stat[i] = 0; cnt[i] = 0; pri[i] = 0; wake[i] = 0;
        end
        cur = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: ticks and yield fall back to slot 0
        add_row(FN_TICK, 32'd0, 16'd0, 4'd0, 8'd0, '{1, 4'd0, 1, 1});
        add_row(FN_YIELD, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 8'hFF, '{1, 4'd0, 1, 1});
        add_row(FN_EXIT, 32'd5, 16'd0, 4'd3, 8'd0, '{1, 4'd0, 0, 0}); // absent: ignored
        add_row(3'd5, 32'd5, 16'd0, 4'd3, 8'd7, '{1, 4'd0, 0, 0});
        add_row(3'd7, 32'd5, 16'd0, 4'd3, 8'd7, '{1, 4'd0, 0, 0});
        add_row(FN_INSTALL, 32'd1, 16'd0, 4'd15, 8'd255, '{1, 4'd0, 0, 0});
        add_row(FN_INSTALL, 32'd1, 16'd0, 4'd0, 8'd0, '{1, 4'd0, 0, 0}); // prio 0 as 1
        add_row(FN_INSTALL, 32'd1, 16'd0, 4'd4, 8'd3, '{1, 4'd0, 0, 0});
        add_row(FN_YIELD, 32'd2, 16'd0, 4'd0, 8'd0, '{1, 4'd15, 1, 0});
        add_row(FN_TICK, 32'd3, 16'd0, 4'd0, 8'd0, nk);
        add_row(FN_SLEEP, 32'd10, 16'hFFFF, 4'd0, 8'd0, nk);
        add_row(FN_SLEEP, 32'hFFFF_FF00, 16'd1, 4'd0, 8'd0, nk); // wake wraps
        add_row(FN_TICK, 32'd20, 16'd0, 4'd0, 8'd0, nk);
        add_row(FN_EXIT, 32'd20, 16'd0, 4'd4, 8'd0, nk);
        add_row(FN_EXIT, 32'd20, 16'd0, 4'd0, 8'd0, nk);
        add_row(FN_YIELD, 32'd30, 16'd0, 4'd0, 8'd0, nk);
        add_row(FN_SLEEP, 32'd40, 16'd0, 4'd0, 8'd0, nk);
        add_row(FN_YIELD, 32'd41, 16'd0, 4'd0, 8'd0, nk);
        for (int k = 0; k < 6; k++) add_row(FN_TICK, 32'd50, 16'd0, 4'd0, 8'd0, nk);
        for (int k = 0; k < dir_cmd.size(); k++) send_beat(dir_cmd[k], dir_exp[k]);

        clock_ms = 32'd100;
        for (int n = 0; n < 1850; n++) begin
            r = $urandom_range(0, 99);
            clock_ms = clock_ms + $urandom_range(0, 3000);
            if ($urandom_range(0, 199) == 0) clock_ms = $urandom;
            c.now = clock_ms;
            c.secs = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
            c.slot = 4'($urandom);
            c.prio = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
            if (r < 55) c.func = FN_TICK;
            else if (r < 65) c.func = FN_SLEEP;
            else if (r < 75) c.func = FN_YIELD;
            else if (r < 88) c.func = FN_INSTALL;
            else if (r < 97) c.func = FN_EXIT;
            else c.func = 3'($urandom_range(5, 7));
            send_beat(c, nk);
        end
        i_valid <= 1'b0;
        while (sched_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
